// ===== hw/rtl/prr_pkg.sv =====
`timescale 1ns / 1ps

package prr_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned YAW_W     = 19;
  localparam int unsigned STEP_W    = 20;
  localparam int unsigned YSTEP_W   = 18;
  localparam int unsigned THR_W     = 21;
  localparam int unsigned YTHR_W    = 19;
  localparam int unsigned YAW_EXT_W = 21;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  // angle constants in q16.16
  localparam logic signed [YAW_EXT_W-1:0] PI_Q16     = 21'sd205887;
  localparam logic signed [YAW_EXT_W-1:0] TWO_PI_Q16 = 21'sd411775;

  // floor(n/10) = (n * DIV10_MUL) >> DIV10_SHIFT, exact for n below 2^32
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  typedef enum logic [1:0] {
    REG_STEP_X   = 2'd0,
    REG_STEP_Y   = 2'd1,
    REG_STEP_Z   = 2'd2,
    REG_STEP_YAW = 2'd3
  } reg_idx_t;

  // register settings plus the precomputed snap thresholds
  typedef struct packed {
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
    logic [STEP_W-1:0]  step_z;
    logic [YSTEP_W-1:0] step_yaw;
    logic [THR_W-1:0]   thr_x;
    logic [THR_W-1:0]   thr_y;
    logic [THR_W-1:0]   thr_z;
    logic [YTHR_W-1:0]  thr_yaw;
  } cfg_t;

endpackage

// ===== hw/rtl/prr_cfg.sv =====
`timescale 1ns / 1ps

module prr_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prr_pkg::ADDR_W-1:0]   paddr,
  input  logic [prr_pkg::DATA_W-1:0]   pwdata,
  output logic [prr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output prr_pkg::cfg_t                cfg
);

  prr_pkg::cfg_t     cfg_r;
  prr_pkg::cfg_t     cfg_nxt;
  prr_pkg::reg_idx_t idx;
  logic              wr_en;
  logic [19:0]       wstep;
  logic [23:0]       wstep11;
  logic [55:0]       prod;
  logic [20:0]       wthr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = prr_pkg::reg_idx_t'(paddr[3:2]);

  // one shared divide-by-ten multiplier: only one register is written per transfer
  always_comb begin
    if (idx == prr_pkg::REG_STEP_YAW) begin
      wstep = {2'b00, pwdata[prr_pkg::YSTEP_W-1:0]};
    end else begin
      wstep = pwdata[prr_pkg::STEP_W-1:0];
    end
    wstep11 = {1'b0, wstep, 3'b000} + {3'b000, wstep, 1'b0} + {4'b0000, wstep};
    prod    = {32'd0, wstep11} * {24'd0, prr_pkg::DIV10_MUL};
    wthr    = prod[55:35];
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        prr_pkg::REG_STEP_X: begin
          cfg_nxt.step_x = wstep;
          cfg_nxt.thr_x  = wthr;
        end
        prr_pkg::REG_STEP_Y: begin
          cfg_nxt.step_y = wstep;
          cfg_nxt.thr_y  = wthr;
        end
        prr_pkg::REG_STEP_Z: begin
          cfg_nxt.step_z = wstep;
          cfg_nxt.thr_z  = wthr;
        end
        prr_pkg::REG_STEP_YAW: begin
          cfg_nxt.step_yaw = wstep[prr_pkg::YSTEP_W-1:0];
          cfg_nxt.thr_yaw  = wthr[prr_pkg::YTHR_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      prr_pkg::REG_STEP_X:   prdata = {12'd0, cfg_r.step_x};
      prr_pkg::REG_STEP_Y:   prdata = {12'd0, cfg_r.step_y};
      prr_pkg::REG_STEP_Z:   prdata = {12'd0, cfg_r.step_z};
      prr_pkg::REG_STEP_YAW: prdata = {14'd0, cfg_r.step_yaw};
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/prr_lin.sv =====
`timescale 1ns / 1ps

module prr_lin (
  input  logic signed [prr_pkg::POS_W-1:0]  cur,
  input  logic signed [prr_pkg::POS_W-1:0]  tgt,
  input  logic        [prr_pkg::STEP_W-1:0] step,
  input  logic        [prr_pkg::THR_W-1:0]  thr,
  output logic signed [prr_pkg::POS_W-1:0]  nxt
);

  logic signed [32:0] diff;
  logic        [32:0] gap;
  logic        [32:0] cur_e;
  logic        [32:0] step_e;
  logic        [32:0] moved;

  always_comb begin
    diff   = {cur[31], cur} - {tgt[31], tgt};
    gap    = diff[32] ? 33'(-diff) : 33'(diff);
    cur_e  = {cur[31], cur};
    step_e = {13'd0, step};
    // never passes the target, so the 32-bit result cannot overflow
    moved  = diff[32] ? (cur_e + step_e) : (cur_e - step_e);
    if (gap <= {12'd0, thr}) begin
      nxt = tgt;
    end else begin
      nxt = moved[31:0];
    end
  end

endmodule

// ===== hw/rtl/prr_yaw.sv =====
`timescale 1ns / 1ps

module prr_yaw (
  input  logic signed [prr_pkg::YAW_W-1:0]   cur,
  input  logic signed [prr_pkg::YAW_W-1:0]   tgt_raw,
  input  logic        [prr_pkg::YSTEP_W-1:0] step,
  input  logic        [prr_pkg::YTHR_W-1:0]  thr,
  output logic signed [prr_pkg::YAW_W-1:0]   tgt,
  output logic signed [prr_pkg::YAW_W-1:0]   nxt
);

  function automatic logic signed [20:0] wrap(input logic signed [20:0] v);
    if (v > prr_pkg::PI_Q16) begin
      return v - prr_pkg::TWO_PI_Q16;
    end else if (v < -prr_pkg::PI_Q16) begin
      return v + prr_pkg::TWO_PI_Q16;
    end else begin
      return v;
    end
  endfunction

  logic signed [20:0] tgt_e;
  logic signed [20:0] cur_e;
  logic signed [20:0] step_e;
  logic signed [20:0] d;
  logic        [20:0] absd;
  logic               up;
  logic signed [20:0] moved;

  always_comb begin
    tgt_e  = wrap({{2{tgt_raw[18]}}, tgt_raw});
    cur_e  = {{2{cur[18]}}, cur};
    step_e = {3'b000, step};
    d      = cur_e - tgt_e;
    absd   = d[20] ? 21'(-d) : 21'(d);
    // short way round when the gap exceeds pi
    priority if (d > prr_pkg::PI_Q16) begin
      up = 1'b1;
    end else if (d < -prr_pkg::PI_Q16) begin
      up = 1'b0;
    end else begin
      up = d[20];
    end
    moved = wrap(up ? (cur_e + step_e) : (cur_e - step_e));
    tgt   = tgt_e[18:0];
    if (absd <= {2'b00, thr}) begin
      nxt = tgt_e[18:0];
    end else begin
      nxt = moved[18:0];
    end
  end

endmodule

// ===== hw/rtl/pose_reference_ramp.sv =====
`timescale 1ns / 1ps

// four-axis reference ramp (slew-rate limiter) for x, y, z and yaw
// in_ channel: one target pose plus force flag per control tick, transfer
//   when in_valid is high and in_stall is low
// out_ channel: one updated reference per tick, transfer when out_valid is
//   high and out_stall is low
// path: a tick passes through the input register, then the result register,
//   which raises out_valid; a stalled output can hold it in the input register;
//   throughput one tick per cycle while out_stall is low, set by the ramp logic
//   between the two registers and the reference registers it updates
// a stalled result holds in the result register while one more tick waits in
//   the input register; in_stall rises only when both are full
// step registers sit on the apb port at 0x0, 0x4, 0x8, 0xc; a write also
//   stores floor(step*11/10) as the snap threshold, ready the next cycle
// reset clears the steps, thresholds and reference pose to zero and empties
//   both pipeline registers
module pose_reference_ramp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [prr_pkg::POS_W-1:0]     in_target_x,
  input  logic signed [prr_pkg::POS_W-1:0]     in_target_y,
  input  logic signed [prr_pkg::POS_W-1:0]     in_target_z,
  input  logic signed [prr_pkg::YAW_W-1:0]     in_target_yaw,
  input  logic                                 in_force_req,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [prr_pkg::POS_W-1:0]     out_ref_x_out,
  output logic signed [prr_pkg::POS_W-1:0]     out_ref_y_out,
  output logic signed [prr_pkg::POS_W-1:0]     out_ref_z_out,
  output logic signed [prr_pkg::YAW_W-1:0]     out_ref_yaw_out,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [prr_pkg::ADDR_W-1:0]           paddr,
  input  logic [prr_pkg::DATA_W-1:0]           pwdata,
  output logic [prr_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);

  prr_pkg::cfg_t cfg;

  logic                              in_vld_r, in_vld_nxt;
  logic signed [prr_pkg::POS_W-1:0]  tx_r, ty_r, tz_r;
  logic signed [prr_pkg::YAW_W-1:0]  tyaw_r;
  logic                              force_r;

  logic                              out_vld_r, out_vld_nxt;
  logic signed [prr_pkg::POS_W-1:0]  rx_r, ry_r, rz_r;
  logic signed [prr_pkg::YAW_W-1:0]  ryaw_r;

  logic signed [prr_pkg::POS_W-1:0]  ramp_x, ramp_y, ramp_z;
  logic signed [prr_pkg::YAW_W-1:0]  ramp_yaw, tyaw_w;
  logic signed [prr_pkg::POS_W-1:0]  nx, ny, nz;
  logic signed [prr_pkg::YAW_W-1:0]  nyaw;

  logic out_free;
  logic adv;
  logic in_take;

  prr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prr_lin u_lin_x (
    .cur  (rx_r),
    .tgt  (tx_r),
    .step (cfg.step_x),
    .thr  (cfg.thr_x),
    .nxt  (ramp_x)
  );

  prr_lin u_lin_y (
    .cur  (ry_r),
    .tgt  (ty_r),
    .step (cfg.step_y),
    .thr  (cfg.thr_y),
    .nxt  (ramp_y)
  );

  prr_lin u_lin_z (
    .cur  (rz_r),
    .tgt  (tz_r),
    .step (cfg.step_z),
    .thr  (cfg.thr_z),
    .nxt  (ramp_z)
  );

  prr_yaw u_yaw (
    .cur     (ryaw_r),
    .tgt_raw (tyaw_r),
    .step    (cfg.step_yaw),
    .thr     (cfg.thr_yaw),
    .tgt     (tyaw_w),
    .nxt     (ramp_yaw)
  );

  always_comb begin
    if (force_r) begin
      nx   = tx_r;
      ny   = ty_r;
      nz   = tz_r;
      nyaw = tyaw_w;
    end else begin
      nx   = ramp_x;
      ny   = ramp_y;
      nz   = ramp_z;
      nyaw = ramp_yaw;
    end
  end

  // the result register doubles as the reference state
  assign out_free = !out_vld_r || !out_stall;
  assign adv      = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_free) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      rx_r      <= '0;
      ry_r      <= '0;
      rz_r      <= '0;
      ryaw_r    <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        rx_r   <= nx;
        ry_r   <= ny;
        rz_r   <= nz;
        ryaw_r <= nyaw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tx_r    <= in_target_x;
      ty_r    <= in_target_y;
      tz_r    <= in_target_z;
      tyaw_r  <= in_target_yaw;
      force_r <= in_force_req;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_ref_x_out   = rx_r;
  assign out_ref_y_out   = ry_r;
  assign out_ref_z_out   = rz_r;
  assign out_ref_yaw_out = ryaw_r;

endmodule
